[hdl/wsp_pkg.sv]
// Shared types, widths and constants for the world-to-screen projection block.
package wsp_pkg;

  localparam int unsigned ScreenWDef = 1024;
  localparam int unsigned ScreenHDef = 768;

  localparam int unsigned NCoef   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  localparam int unsigned PosW  = 32;
  localparam int unsigned ClipW = 49;
  localparam int unsigned MagW  = 48;
  localparam int unsigned HalfW = 13;
  localparam int unsigned NumW  = MagW + HalfW;
  localparam int unsigned QuotW = 34;
  localparam int unsigned NShW  = QuotW - 16;
  localparam int unsigned SumW  = QuotW + 3;

  localparam logic signed [ClipW-1:0] WMinQ16 = ClipW'(6554);

  typedef logic [NCoef-1:0][CfgW-1:0] coef_bank_t;

  typedef struct packed {
    logic            vis;
    logic            neg_x;
    logic            neg_y;
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic [MagW-1:0] den;
  } job_t;

  typedef struct packed {
    logic [MagW-1:0]  rem;
    logic [NShW-1:0]  nlo;
    logic [QuotW-1:0] quot;
    logic             neg;
    logic             ovf;
    logic [MagW-1:0]  den;
  } div_stage_t;

  function automatic logic signed [PosW-1:0] elem(coef_bank_t c, logic [3:0] i);
    return signed'(i[0] ? c[i[3:1]][63:32] : c[i[3:1]][31:0]);
  endfunction

endpackage

[hdl/world_to_screen_projection.sv]
// Top level of the world-to-screen projection block: registers, front, queue and back.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+------------------------------------
//   input   | in_valid_i | in_stall_o  | pos_x_i, pos_y_i, pos_z_i
//   output  | out_valid_o| out_stall_i | visible_o, screen_x_o, screen_y_o
//   config  | cfg_we_i   | -           | cfg_idx_i, cfg_data_i
//
// One item per cycle unless out_stall_i holds it; items pass the front registers,
// the queue, the 34-stage divider (one quotient bit each) and the output register.
// Reset clears all control state and the matrix registers; no clearing pass.
// A stall on a valid output freezes the back part; the 4-deep queue lets the front
// keep taking items until it fills, then in_stall_o rises.
module world_to_screen_projection #(
  parameter int unsigned SCREEN_W = wsp_pkg::ScreenWDef,
  parameter int unsigned SCREEN_H = wsp_pkg::ScreenHDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [wsp_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_i,
  input  logic signed [31:0]            pos_y_i,
  input  logic signed [31:0]            pos_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          visible_o,
  output logic signed [31:0]            screen_x_o,
  output logic signed [31:0]            screen_y_o
);

  wsp_pkg::coef_bank_t coef_q;
  wsp_pkg::job_t f_job, q_job;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  wsp_front #(.SCREEN_W (SCREEN_W), .SCREEN_H (SCREEN_H)) u_front (
    .clk_i (clk_i), .rst_ni (rst_ni), .coef_i (coef_q), .valid_i (in_valid_i),
    .pos_x_i (pos_x_i), .pos_y_i (pos_y_i), .pos_z_i (pos_z_i),
    .full_i (q_full), .stall_o (in_stall_o), .push_o (push), .job_o (f_job)
  );

  wsp_queue u_queue (
    .clk_i (clk_i), .rst_ni (rst_ni), .push_i (push), .job_i (f_job),
    .pop_i (pop), .full_o (q_full), .empty_o (q_empty), .job_o (q_job)
  );

  wsp_back #(.SCREEN_W (SCREEN_W), .SCREEN_H (SCREEN_H)) u_back (
    .clk_i (clk_i), .rst_ni (rst_ni), .empty_i (q_empty), .job_i (q_job),
    .pop_o (pop), .stall_i (out_stall_i), .valid_o (out_valid_o),
    .visible_o (visible_o), .screen_x_o (screen_x_o), .screen_y_o (screen_y_o)
  );

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !visible_o) |-> (screen_x_o == 0 && screen_y_o == 0))
    else $error("hidden item with non-zero screen position");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("queue read while empty");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

[hdl/wsp_front.sv]
// Front part: matrix transform to clip space, visibility test and numerator scaling.
module wsp_front #(
  parameter int unsigned SCREEN_W = wsp_pkg::ScreenWDef,
  parameter int unsigned SCREEN_H = wsp_pkg::ScreenHDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wsp_pkg::coef_bank_t      coef_i,
  input  logic                     valid_i,
  input  logic signed [31:0]       pos_x_i,
  input  logic signed [31:0]       pos_y_i,
  input  logic signed [31:0]       pos_z_i,
  input  logic                     full_i,
  output logic                     stall_o,
  output logic                     push_o,
  output wsp_pkg::job_t            job_o
);

  localparam int unsigned RowIdx [3] = '{0, 1, 3};
  localparam logic [wsp_pkg::NumW-1:0] HalfX = wsp_pkg::NumW'(SCREEN_W / 2);
  localparam logic [wsp_pkg::NumW-1:0] HalfY = wsp_pkg::NumW'(SCREEN_H / 2);

  logic signed [31:0] pos [3];
  logic signed [63:0] prod_q [3][3];
  logic signed [31:0] trans_q [3];
  logic signed [wsp_pkg::ClipW-1:0] clip_q [3];
  logic signed [wsp_pkg::ClipW-1:0] clip_d [3];
  logic v1_q, v2_q, v3_q, en;
  logic [wsp_pkg::MagW-1:0] mag [2];
  wsp_pkg::job_t job_d, job_q;

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  assign en      = !(v3_q && full_i);
  assign stall_o = !en;
  assign push_o  = v3_q && !full_i;
  assign job_o   = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[r][k] <= 64'(pos[k]) * 64'(wsp_pkg::elem(coef_i, 4'(RowIdx[r] + 4 * k)));
        end
        trans_q[r] <= wsp_pkg::elem(coef_i, 4'(RowIdx[r] + 12));
        clip_q[r]  <= clip_d[r];
      end
      job_q <= job_d;
    end
  end

  always_comb begin
    logic signed [63:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = (prod_q[r][0] >>> 16) + (prod_q[r][1] >>> 16) + (prod_q[r][2] >>> 16)
          + 64'(trans_q[r]);
      clip_d[r] = acc[wsp_pkg::ClipW-1:0];
    end
    for (int r = 0; r < 2; r++) begin
      mag[r] = clip_q[r][wsp_pkg::ClipW-1] ? wsp_pkg::MagW'(-clip_q[r])
                                           : clip_q[r][wsp_pkg::MagW-1:0];
    end
    job_d.vis   = clip_q[2] >= wsp_pkg::WMinQ16;
    job_d.neg_x = clip_q[0][wsp_pkg::ClipW-1];
    job_d.neg_y = clip_q[1][wsp_pkg::ClipW-1];
    job_d.num_x = wsp_pkg::NumW'(mag[0]) * HalfX;
    job_d.num_y = wsp_pkg::NumW'(mag[1]) * HalfY;
    job_d.den   = clip_q[2][wsp_pkg::MagW-1:0];
  end

endmodule

[hdl/wsp_queue.sv]
// Short queue of jobs between the front and back parts.
module wsp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  wsp_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output wsp_pkg::job_t job_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  wsp_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

[hdl/wsp_div_lane.sv]
// Pipelined restoring divider lane, one quotient bit per stage, with overflow flag.
module wsp_div_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic                          neg_i,
  input  logic [wsp_pkg::NumW-1:0]      num_i,
  input  logic [wsp_pkg::MagW-1:0]      den_i,
  output logic [wsp_pkg::QuotW-1:0]     quot_o,
  output logic                          ovf_o,
  output logic                          neg_o
);

  localparam int unsigned QW = wsp_pkg::QuotW;
  localparam int unsigned SW = wsp_pkg::NShW;
  localparam int unsigned MW = wsp_pkg::MagW;
  localparam int unsigned CW = MW + SW;

  wsp_pkg::div_stage_t st_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem  <= MW'(num_i >> SW);
      st_q[0].nlo  <= num_i[SW-1:0];
      st_q[0].quot <= '0;
      st_q[0].neg  <= neg_i;
      st_q[0].ovf  <= CW'(num_i) >= {den_i, SW'(0)};
      st_q[0].den  <= den_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic          nbit;
    logic [MW:0]   sh;
    logic          ge;
    if (k < SW) begin : g_b
      assign nbit = st_q[k].nlo[SW-1-k];
    end else begin : g_z
      assign nbit = 1'b0;
    end
    assign sh = {st_q[k].rem, nbit};
    assign ge = sh >= {1'b0, st_q[k].den};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1].rem  <= ge ? MW'(sh - {1'b0, st_q[k].den}) : sh[MW-1:0];
        st_q[k+1].nlo  <= st_q[k].nlo;
        st_q[k+1].quot <= {st_q[k].quot[QW-2:0], ge};
        st_q[k+1].neg  <= st_q[k].neg;
        st_q[k+1].ovf  <= st_q[k].ovf;
        st_q[k+1].den  <= st_q[k].den;
      end
    end
  end

  assign quot_o = st_q[QW].quot;
  assign ovf_o  = st_q[QW].ovf;
  assign neg_o  = st_q[QW].neg;

endmodule

[hdl/wsp_back.sv]
// Back part: two divider lanes, viewport offset, saturation and output register.
module wsp_back #(
  parameter int unsigned SCREEN_W = wsp_pkg::ScreenWDef,
  parameter int unsigned SCREEN_H = wsp_pkg::ScreenHDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  wsp_pkg::job_t      job_i,
  output logic               pop_o,
  input  logic               stall_i,
  output logic               valid_o,
  output logic               visible_o,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o
);

  localparam int unsigned QW = wsp_pkg::QuotW;
  localparam int unsigned SW = wsp_pkg::SumW;
  localparam logic signed [SW-1:0] OffX = SW'((SCREEN_W / 2) * 65536);
  localparam logic signed [SW-1:0] OffY = SW'((SCREEN_H / 2) * 65536);
  localparam logic signed [SW-1:0] SMax = SW'(32'h7fff_ffff);
  localparam logic signed [SW-1:0] SMin = -SW'(33'h0_8000_0000);

  logic en;
  logic [QW:0] vld_q, vis_q;
  logic out_vld_q, out_vis_q;
  logic signed [31:0] sx_q, sy_q, sx_d, sy_d;
  logic [QW-1:0] qx, qy;
  logic ovx, ovy, ngx, ngy;

  assign en    = !out_vld_q || !stall_i;
  assign pop_o = en && !empty_i;

  wsp_div_lane u_lane_x (
    .clk_i (clk_i), .en_i (en), .neg_i (job_i.neg_x), .num_i (job_i.num_x),
    .den_i (job_i.den), .quot_o (qx), .ovf_o (ovx), .neg_o (ngx)
  );

  wsp_div_lane u_lane_y (
    .clk_i (clk_i), .en_i (en), .neg_i (job_i.neg_y), .num_i (job_i.num_y),
    .den_i (job_i.den), .quot_o (qy), .ovf_o (ovy), .neg_o (ngy)
  );

  function automatic logic signed [31:0] clamp(logic signed [SW-1:0] v);
    if (v > SMax) return 32'sh7fff_ffff;
    if (v < SMin) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  always_comb begin
    logic signed [SW-1:0] tx, ty;
    tx = ngx ? -SW'(qx) : SW'(qx);
    ty = ngy ? -SW'(qy) : SW'(qy);
    if (!vis_q[QW])  sx_d = '0;
    else if (ovx)    sx_d = ngx ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else             sx_d = clamp(OffX + tx);
    if (!vis_q[QW])  sy_d = '0;
    else if (ovy)    sy_d = ngy ? 32'sh7fff_ffff : 32'sh8000_0000;
    else             sy_d = clamp(OffY - ty);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[QW-1:0], pop_o};
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_q     <= {vis_q[QW-1:0], job_i.vis};
      out_vis_q <= vis_q[QW];
      sx_q      <= sx_d;
      sy_q      <= sy_d;
    end
  end

  assign valid_o    = out_vld_q;
  assign visible_o  = out_vis_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;

endmodule

[test/world_to_screen_projection_test.sv]
// Testbench for the world-to-screen projection block: random and directed points against a predictor.
module world_to_screen_projection_test;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  typedef struct {
    logic               vis;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } screen_t;

  localparam int HALF_W = 1024 / 2;
  localparam int HALF_H = 768 / 2;
  localparam longint W_MIN = 6554;
  localparam longint RATIO_CAP = 64'sd1 << 40;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [wsp_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [wsp_pkg::CfgW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic vis;
  logic signed [31:0] scr_x, scr_y;

  logic [wsp_pkg::CfgW-1:0] matrix [wsp_pkg::NCoef];
  point_t  pending_points[$];
  screen_t expected_screens[$];
  int errors = 0;
  longint cycles = 0;
  bit in_taken = 0;
  bit hold_sender = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0, stall_mode = 0;

  always #5 clk = ~clk;

  world_to_screen_projection i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .visible_o(vis), .screen_x_o(scr_x), .screen_y_o(scr_y)
  );

  function automatic longint coef(int i);
    logic [63:0] r;
    r = matrix[i >> 1];
    return longint'(signed'((i & 1) ? r[63:32] : r[31:0]));
  endfunction

  function automatic longint clip_term(int row, longint x, longint y, longint z);
    return ((x * coef(row)) >>> 16) + ((y * coef(row + 4)) >>> 16)
         + ((z * coef(row + 8)) >>> 16) + coef(row + 12);
  endfunction

  // (half * c * 2^16) / w, truncated toward zero, magnitude capped
  function automatic longint viewport_ratio(longint half, longint c, longint w);
    logic [127:0] num, q;
    logic [127:0] mag;
    longint qs;
    mag = (c < 0) ? 128'(-c) : 128'(c);
    num = (mag * 128'(half)) << 16;
    q = num / 128'(w);
    if (q > 128'(RATIO_CAP)) q = 128'(RATIO_CAP);
    qs = longint'(q[63:0]);
    return (c < 0) ? -qs : qs;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic screen_t project_point(point_t p);
    screen_t s;
    longint x, y, z, cx, cy, cw;
    x = p.px; y = p.py; z = p.pz;
    cx = clip_term(0, x, y, z);
    cy = clip_term(1, x, y, z);
    cw = clip_term(3, x, y, z);
    if (cw < W_MIN) begin
      s.vis = 1'b0; s.sx = '0; s.sy = '0;
    end else begin
      s.vis = 1'b1;
      s.sx = clamp32(viewport_ratio(HALF_W, cx, cw) + longint'(HALF_W) * 65536);
      s.sy = clamp32(longint'(HALF_H) * 65536 - viewport_ratio(HALF_H, cy, cw));
    end
    return s;
  endfunction

  // driver
  always @(negedge clk) begin
    point_t p;
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold payload
      end else if (pending_points.size() != 0 && !hold_sender && gap_left == 0) begin
        p = pending_points[0];
        in_valid <= 1'b1;
        pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
        end else if (burst_left == 1) begin
          burst_left <= 0;
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (stall_phase % 5) < 2;
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // predictor on acceptance, checker on output
  always @(posedge clk) begin
    point_t p;
    screen_t e;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (in_valid && !in_stall) begin
        p.px = pos_x; p.py = pos_y; p.pz = pos_z;
        expected_screens.push_back(project_point(p));
        void'(pending_points.pop_front());
        in_taken = 1'b1;
      end else begin
        in_taken = 1'b0;
      end
      if (out_valid && !out_stall) begin
        if (expected_screens.size() == 0) begin
          errors++;
          $display("%0t: unexpected item vis=%0b x=%0d y=%0d", $time, vis, scr_x, scr_y);
        end else begin
          e = expected_screens.pop_front();
          if (vis !== e.vis) begin
            errors++;
            $display("%0t: visible exp %0b got %0b", $time, e.vis, vis);
          end
          if (scr_x !== e.sx) begin
            errors++;
            $display("%0t: screen_x exp %0d got %0d", $time, e.sx, scr_x);
          end
          if (scr_y !== e.sy) begin
            errors++;
            $display("%0t: screen_y exp %0d got %0d", $time, e.sy, scr_y);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20)) - 10) << 16;
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
      3: return 32'($urandom_range(0, 600)) << 16;
      4: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
      default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.px = rand_q16(); p.py = rand_q16(); p.pz = rand_q16();
    return p;
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.px = x; p.py = y; p.pz = z;
    pending_points.push_back(p);
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0 || in_valid || expected_screens.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(int idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= wsp_pkg::CfgIdxW'(idx);
    cfg_data <= val;
    matrix[idx] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // kind 0 gives cx = x + y, w = z + 1.0; 1 random; 2, 3 extreme; else random, set w z-scale, offset
  task automatic load_matrix(int kind);
    logic [63:0] m [wsp_pkg::NCoef];
    int k;
    case (kind)
      0: begin
        for (k = 0; k < wsp_pkg::NCoef; k++) m[k] = '0;
        m[0] = {32'h0, 32'h0001_0000};
        m[2] = {32'h0, 32'h0001_0000};
        m[5] = {32'h0001_0000, 32'h0};
        m[7] = {32'h0001_0000, 32'h0};
      end
      1: begin
        for (k = 0; k < wsp_pkg::NCoef; k++) m[k] = {$urandom(), $urandom()};
      end
      2: begin
        for (k = 0; k < wsp_pkg::NCoef; k++) m[k] = {32'h7fffffff, 32'h80000000};
      end
      3: begin
        for (k = 0; k < wsp_pkg::NCoef; k++) m[k] = {64{1'b1}};
      end
      default: begin
        for (k = 0; k < wsp_pkg::NCoef; k++)
          m[k] = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom()),
                  {16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
        m[5][63:32] = 32'($urandom_range(1, 4)) << 14;
        m[7][63:32] = 32'($urandom_range(0, 8)) << 16;
      end
    endcase
    for (k = 0; k < wsp_pkg::NCoef; k++) write_coef(k, m[k]);
  endtask

  initial begin
    int ph, n, k;
    for (k = 0; k < wsp_pkg::NCoef; k++) matrix[k] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all-zero matrix: w is 0, never visible
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h7fffffff, 32'h80000000, 32'hffffffff);
    wait_drained();

    load_matrix(0);
    add_point(32'h0, 32'h0, 32'h0001_0000);
    add_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
    add_point(32'h0, 32'h0, 32'd6554);
    add_point(32'h0, 32'h0, 32'd6553);
    add_point(32'h0, 32'h0, 32'hffff_0000);
    add_point(32'h7fffffff, 32'h80000000, 32'd6554);
    add_point(32'h80000000, 32'h7fffffff, 32'd6554);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h80000000, 32'h7fffffff);
    add_point(32'h0000_8000, 32'h0000_8000, 32'h0002_0000);
    add_point(32'hffffffff, 32'h1, 32'h1);
    wait_drained();

    load_matrix(2);
    add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'h0001_0000, 32'h0, 32'h0);
    wait_drained();
    load_matrix(3);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'h0, 32'h0, 32'h0);
    wait_drained();

    for (ph = 0; ph < 8; ph++) begin
      load_matrix(ph == 3 ? 1 : (ph == 6 ? 0 : 4));
      for (n = 0; n < 130; n++) pending_points.push_back(rand_point());
      if (ph == 4) begin
        while (pending_points.size() > 60) @(posedge clk);
        hold_sender = 1;
        while (in_valid || expected_screens.size() != 0) @(posedge clk);
        hold_sender = 0;
      end
      wait_drained();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
